// ===== rtl/core/msb_pkg.sv =====
package msb_pkg;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    // Depth of the command queue between the front and the back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    // What the back has to do with a queued command.
    typedef enum logic [1:0] {
        K_PUSH   = 2'd0,
        K_POP    = 2'd1,
        K_PEEK   = 2'd2,
        K_REPORT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        BE_IDLE = 2'd0,
        BE_EXEC = 2'd1,
        BE_FIN  = 2'd2
    } be_state_t;

    typedef struct packed {
        kind_t                kind;
        logic [INDEX_W-1:0]   stack_index;
        logic [VALUE_W-1:0]   push_value;
        status_t              status;
    } q_entry_t;

endpackage

// ===== rtl/core/msb_ram.sv =====
module msb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/msb_front.sv =====
module msb_front #(
    parameter int NUM_STACKS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [msb_pkg::OP_W-1:0]     op,
    input  logic [msb_pkg::INDEX_W-1:0]  stack_index,
    input  logic [msb_pkg::VALUE_W-1:0]  push_value,
    output logic                         q_valid,
    output msb_pkg::q_entry_t            q_entry,
    input  logic                         q_pop
);

    import msb_pkg::*;

    localparam int SEL_W = INDEX_W + $clog2(NUM_STACKS + 1);

    q_entry_t            entry_mem_reg [QDEPTH];
    q_entry_t            cls_entry;
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                stack_ok;
    logic                accept;
    logic                drain;

    assign stack_ok = ({{(SEL_W - INDEX_W){1'b0}}, stack_index} < SEL_W'(NUM_STACKS));

    // Classify: a bad stack number or an unused op is answered without touching state.
    always_comb
    begin
        cls_entry.stack_index = stack_index;
        cls_entry.push_value  = push_value;
        cls_entry.kind        = K_REPORT;
        cls_entry.status      = ST_OK;
        unique case (op)
            OP_PUSH:
            begin
                cls_entry.kind   = stack_ok ? K_PUSH : K_REPORT;
                cls_entry.status = ST_OVERFLOW;
            end
            OP_POP:
            begin
                cls_entry.kind   = stack_ok ? K_POP : K_REPORT;
                cls_entry.status = ST_EMPTY;
            end
            OP_PEEK:
            begin
                cls_entry.kind   = stack_ok ? K_PEEK : K_REPORT;
                cls_entry.status = ST_EMPTY;
            end
            default:
            begin
                cls_entry.kind   = K_REPORT;
                cls_entry.status = ST_OK;
            end
        endcase
    end

    assign busy    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_mem_reg[rd_ptr_reg];
    assign accept  = start && !busy;
    assign drain   = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (drain)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !drain)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (drain && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_mem_reg[wr_ptr_reg] <= cls_entry;
        end
    end

endmodule

// ===== rtl/core/msb_back.sv =====
module msb_back #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  msb_pkg::q_entry_t            q_entry,
    output logic                         q_pop,
    output logic                         done,
    output logic [msb_pkg::STAT_W-1:0]   status,
    output logic [msb_pkg::VALUE_W-1:0]  top_value
);

    import msb_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int LINK_W = $clog2(CAPACITY + 1);
    localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LINK_W-1:0] LINK_NULL = {LINK_W{1'b1}};
    localparam logic [LINK_W-1:0] LAST_SLOT = LINK_W'(CAPACITY - 1);

    be_state_t               state_reg;
    be_state_t               state_next;
    q_entry_t                cur_reg;
    q_entry_t                cur_next;
    logic [LINK_W-1:0]       free_head_reg;
    logic [LINK_W-1:0]       free_head_next;
    logic [LINK_W-1:0]       hwm_reg;
    logic [LINK_W-1:0]       hwm_next;
    logic [NUM_STACKS-1:0]   head_valid_reg;
    logic [NUM_STACKS-1:0]   head_valid_next;
    logic [LINK_W-1:0]       slot_reg;
    logic [LINK_W-1:0]       slot_next;
    logic [LINK_W-1:0]       rslot_reg;
    logic [LINK_W-1:0]       rslot_next;
    logic                    done_reg;
    logic                    done_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic [VALUE_W-1:0]      top_reg;
    logic [VALUE_W-1:0]      top_next;

    logic [SIDX_W-1:0]       sidx_cur;
    logic [SIDX_W-1:0]       sidx_q;

    logic                    head_we;
    logic [SIDX_W-1:0]       head_waddr;
    logic [LINK_W-1:0]       head_wdata;
    logic                    head_re;
    logic [LINK_W-1:0]       head_rdata;
    logic [LINK_W-1:0]       head_eff;

    logic                    link_we;
    logic [IDX_W-1:0]        link_waddr;
    logic [LINK_W-1:0]       link_wdata;
    logic                    link_re;
    logic [IDX_W-1:0]        link_raddr;
    logic [LINK_W-1:0]       link_rdata;
    logic [LINK_W-1:0]       link_dflt;
    logic [LINK_W-1:0]       link_eff;

    logic                    val_we;
    logic [DATA_WIDTH-1:0]   val_wdata;
    logic                    val_re;
    logic [IDX_W-1:0]        val_raddr;
    logic [DATA_WIDTH-1:0]   val_rdata;
    logic [VALUE_W-1:0]      top_widen;

    assign sidx_cur = SIDX_W'(cur_reg.stack_index);
    assign sidx_q   = SIDX_W'(q_entry.stack_index);

    // A head never written since reset reads as null.
    assign head_eff = head_valid_reg[sidx_cur] ? head_rdata : LINK_NULL;

    // Slots at or above the fill mark were never written: they still chain in order.
    assign link_dflt = (rslot_reg == LAST_SLOT) ? LINK_NULL : rslot_reg + 1'b1;
    assign link_eff  = (rslot_reg >= hwm_reg) ? link_dflt : link_rdata;

    generate
        if (DATA_WIDTH >= VALUE_W)
        begin : g_wide
            assign val_wdata = DATA_WIDTH'(cur_reg.push_value);
            assign top_widen = val_rdata[VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign val_wdata = cur_reg.push_value[DATA_WIDTH-1:0];
            assign top_widen = {{(VALUE_W - DATA_WIDTH){val_rdata[DATA_WIDTH-1]}}, val_rdata};
        end
    endgenerate

    msb_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_STACKS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (sidx_q),
        .rdata (head_rdata)
    );

    msb_ram #(
        .WIDTH (LINK_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    msb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (free_head_reg[IDX_W-1:0]),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BE_IDLE:
            begin
                if (q_valid && (q_entry.kind != K_REPORT))
                begin
                    state_next = BE_EXEC;
                end
            end
            BE_EXEC:
            begin
                if ((cur_reg.kind == K_PUSH) || (head_eff == LINK_NULL))
                begin
                    state_next = BE_IDLE;
                end
                else
                begin
                    state_next = BE_FIN;
                end
            end
            BE_FIN:
            begin
                state_next = BE_IDLE;
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop           = 1'b0;
        head_re         = 1'b0;
        head_we         = 1'b0;
        head_waddr      = sidx_cur;
        head_wdata      = free_head_reg;
        link_re         = 1'b0;
        link_raddr      = free_head_reg[IDX_W-1:0];
        link_we         = 1'b0;
        link_waddr      = free_head_reg[IDX_W-1:0];
        link_wdata      = head_eff;
        val_re          = 1'b0;
        val_raddr       = head_eff[IDX_W-1:0];
        val_we          = 1'b0;
        cur_next        = cur_reg;
        free_head_next  = free_head_reg;
        hwm_next        = hwm_reg;
        head_valid_next = head_valid_reg;
        slot_next       = slot_reg;
        rslot_next      = rslot_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        top_next        = top_reg;
        unique case (state_reg)
            BE_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_entry;
                    if (q_entry.kind == K_REPORT)
                    begin
                        done_next   = 1'b1;
                        status_next = q_entry.status;
                        top_next    = '0;
                    end
                    else
                    begin
                        head_re    = 1'b1;
                        link_re    = 1'b1;
                        rslot_next = free_head_reg;
                    end
                end
            end
            BE_EXEC:
            begin
                case (cur_reg.kind) inside
                    K_PUSH:
                    begin
                        done_next = 1'b1;
                        top_next  = '0;
                        if (free_head_reg == LINK_NULL)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            status_next               = ST_OK;
                            val_we                    = 1'b1;
                            link_we                   = 1'b1;
                            head_we                   = 1'b1;
                            head_valid_next[sidx_cur] = 1'b1;
                            free_head_next            = link_eff;
                            if (free_head_reg == hwm_reg)
                            begin
                                hwm_next = hwm_reg + 1'b1;
                            end
                        end
                    end
                    K_POP, K_PEEK:
                    begin
                        if (head_eff == LINK_NULL)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                            top_next    = '0;
                        end
                        else
                        begin
                            link_re    = 1'b1;
                            link_raddr = head_eff[IDX_W-1:0];
                            rslot_next = head_eff;
                            val_re     = 1'b1;
                            slot_next  = head_eff;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            BE_FIN:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                if (cur_reg.kind == K_POP)
                begin
                    head_we        = 1'b1;
                    head_wdata     = link_eff;
                    link_we        = 1'b1;
                    link_waddr     = slot_reg[IDX_W-1:0];
                    link_wdata     = free_head_reg;
                    free_head_next = slot_reg;
                    top_next       = '0;
                end
                else
                begin
                    top_next = top_widen;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BE_IDLE;
            free_head_reg  <= '0;
            hwm_reg        <= '0;
            head_valid_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            hwm_reg        <= hwm_next;
            head_valid_reg <= head_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        slot_reg   <= slot_next;
        rslot_reg  <= rslot_next;
        status_reg <= status_next;
        top_reg    <= top_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign top_value = top_reg;

endmodule

// ===== rtl/core/multi_stack_shared_buffer.sv =====
// Several LIFO stacks sharing one slot store, with free slots kept on a linked free list.
//
// Command channel: an item (op, stack_index, push_value) is taken on a rising edge with
// start high and busy low. Ops: push, pop, peek top. Busy rises only when the two-entry
// command queue between the front and the back is full.
// Result channel: every item gives exactly one result beat; done is high for one cycle
// with status and top_value. The receiver cannot stall: sample the beat when done is high.
//
// Path of an item: the front classifies and queues it, and the back takes it from the queue.
// The back answers a bad stack number or an unused op code as soon as it takes the item.
// A push, or a pop or peek on an empty stack, finishes in the execute state; a pop or peek
// that finds a slot goes on to the finish state. The back works through the items in order
// and takes the next one only once it is done with the last. A pop or peek needs the stack
// head from the head memory before it can read that slot's link or value: two dependent
// memory reads in its path.
//
// Reset: all stacks empty, free list chained in slot order. No clearing pass: a fill mark
// tracks which link entries were ever written, so the block takes items right after reset.
module multi_stack_shared_buffer #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [msb_pkg::OP_W-1:0]            op,
    input  logic [msb_pkg::INDEX_W-1:0]         stack_index,
    input  logic signed [msb_pkg::VALUE_W-1:0]  push_value,
    output logic                                done,
    output logic [msb_pkg::STAT_W-1:0]          status,
    output logic signed [msb_pkg::VALUE_W-1:0]  top_value
);

    import msb_pkg::*;

    // Queue handoff: front holds classified commands, back drains one per item.
    logic      q_valid;
    q_entry_t  q_entry;
    logic      q_pop;

    // Front: accept beats, check the stack number and op, queue the command.
    msb_front #(
        .NUM_STACKS (NUM_STACKS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .stack_index (stack_index),
        .push_value  (push_value),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop)
    );

    // Back: walk the head, link and value memories and drive the result beat.
    msb_back #(
        .NUM_STACKS (NUM_STACKS),
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .done      (done),
        .status    (status),
        .top_value (top_value)
    );

endmodule

// ===== rtl/core/msb_checker.sv =====
module msb_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [msb_pkg::STAT_W-1:0]          status,
    input  logic signed [msb_pkg::VALUE_W-1:0]  top_value
);

    import msb_pkg::*;

    // Only a successful peek carries a value.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (top_value == '0))
        else $error("result with failing status carries a value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_OK) || (status == ST_OVERFLOW) || (status == ST_EMPTY)))
        else $error("result beat with unknown status code");

    // The queue fills only through an accepted beat.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command beat");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> (!done && !busy))
        else $error("block not quiet leaving reset");

endmodule

bind multi_stack_shared_buffer msb_checker u_msb_checker (.*);
